>>> rtl/dzo_pkg.sv
// Package for the divisor zoom options block: field widths and parameter defaults.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package dzo_pkg;

    // Fixed field widths of the channels
    localparam int DIM_W      = 16;
    localparam int OPT_W      = 16;
    localparam int CNT_W      = 5;
    localparam int OPT_FIELDS = 3;

    // Parameter defaults
    localparam int DIM_BITS_DEF    = 16;
    localparam int MAX_FACTORS_DEF = 16;
    localparam int NUM_OPTIONS_DEF = 3;

endpackage

`default_nettype wire

>>> rtl/dzo_if.sv
// Valid/ready channel interfaces for the divisor zoom options block.
// Depends on dzo_pkg for the field widths.
`default_nettype none

interface dzo_operand_if;
    import dzo_pkg::*;

    logic             valid;
    logic             ready;
    logic [DIM_W-1:0] dimension;
    logic [DIM_W-1:0] start_position;

    modport source (output valid, dimension, start_position, input ready);
    modport sink   (input valid, dimension, start_position, output ready);
endinterface

interface dzo_result_if;
    import dzo_pkg::*;

    logic             valid;
    logic             ready;
    logic [OPT_W-1:0] option_largest;
    logic [OPT_W-1:0] option_middle;
    logic [OPT_W-1:0] option_smallest;
    logic [CNT_W-1:0] valid_count;

    modport source (output valid, option_largest, option_middle, option_smallest,
                    valid_count, input ready);
    modport sink   (input valid, option_largest, option_middle, option_smallest,
                    valid_count, output ready);
endinterface

`default_nettype wire

>>> rtl/divisor_zoom_options_unit.sv
// Divisor zoom options: prime factorisation by trial division and zoom option products.
// Depends on dzo_pkg and on the channel interfaces in dzo_if.sv.
//
// Usage:
//   operand channel: one item carries a dimension and a start position. It is
//   accepted when valid and ready are high at a rising edge; ready is high only
//   while the sequencer is idle, so one item is worked on at a time.
//   result channel: one item per operand, holding the three option products
//   and valid_count. The result sits in an output register; a new operand is
//   taken while it waits, and the finished next result waits in the sequencer
//   until the output register is free, so a stalled receiver loses nothing.
//   Every trial divisor passes through a check step, the shared restoring divider
//   at one bit per cycle and a decision step. There are at most about
//   2^(DIM_BITS/2) trials plus one per factor found; then each stored factor
//   takes a multiply and a compare step through the one multiplier.
//   Dimensions 0 and 1 skip the factorisation and go straight to the result.
//   Reset (rst_n low, asynchronous) returns the sequencer to idle and empties
//   the output register. Nothing is kept from one item to the next.
`default_nettype none

module divisor_zoom_options_unit #(
    parameter int DIM_BITS    = dzo_pkg::DIM_BITS_DEF,
    parameter int MAX_FACTORS = dzo_pkg::MAX_FACTORS_DEF,
    parameter int NUM_OPTIONS = dzo_pkg::NUM_OPTIONS_DEF
) (
    input  wire logic     clk,
    input  wire logic     rst_n,
    dzo_operand_if.sink   operand,
    dzo_result_if.source  result
);
    import dzo_pkg::*;

    localparam int W       = (DIM_BITS > DIM_W) ? DIM_BITS : DIM_W;
    localparam int SQ_W    = 2 * DIM_BITS;
    localparam int FIDX_W  = $clog2(MAX_FACTORS);
    localparam int FCNT_W  = $clog2(MAX_FACTORS + 1);
    localparam int BIT_W   = $clog2(DIM_BITS);
    localparam int VW      = (FCNT_W > CNT_W) ? FCNT_W : CNT_W;

    // Sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_DIV   = 3'd2;
    localparam logic [2:0] S_STEP  = 3'd3;
    localparam logic [2:0] S_MUL   = 3'd4;
    localparam logic [2:0] S_CMP   = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    logic [2:0]          state_reg, state_next;
    logic                out_valid_reg, out_valid_next;

    logic [DIM_BITS-1:0] dim_reg, dim_next;
    logic [DIM_W-1:0]    pos_reg, pos_next;
    logic [DIM_BITS-1:0] rem_reg, rem_next;      // part still to factor
    logic [DIM_BITS-1:0] d_reg, d_next;          // trial divisor
    logic [SQ_W-1:0]     sq_reg, sq_next;        // d squared
    logic [DIM_BITS-1:0] r_reg, r_next;          // divider partial remainder
    logic [DIM_BITS-1:0] q_reg, q_next;          // divider quotient shifter
    logic [BIT_W-1:0]    bit_reg, bit_next;
    logic [FCNT_W-1:0]   cnt_reg, cnt_next;
    logic [FIDX_W-1:0]   idx_reg, idx_next;
    logic [DIM_BITS-1:0] prod_reg, prod_next;
    logic [FCNT_W-1:0]   valid_reg, valid_next;
    logic [DIM_BITS-1:0] fac_reg [MAX_FACTORS];
    logic [DIM_BITS-1:0] fac_next [MAX_FACTORS];
    logic [DIM_BITS-1:0] hist_reg [NUM_OPTIONS];
    logic [DIM_BITS-1:0] hist_next [NUM_OPTIONS];

    logic [OPT_W-1:0]    opt_largest_reg, opt_largest_next;
    logic [OPT_W-1:0]    opt_middle_reg, opt_middle_next;
    logic [OPT_W-1:0]    opt_smallest_reg, opt_smallest_next;
    logic [CNT_W-1:0]    count_reg, count_next;

    logic [W-1:0]        dim_wide;
    logic [DIM_BITS-1:0] dim_in;
    logic [DIM_BITS:0]   r_shift;
    logic                r_ge;
    logic                fits;
    logic [VW-1:0]       valid_wide;
    logic [OPT_W-1:0]    opt [OPT_FIELDS];

    // Input dimension reduced to DIM_BITS
    assign dim_wide = W'(operand.dimension);
    assign dim_in   = dim_wide[DIM_BITS-1:0];

    // One restoring divider step
    assign r_shift = {r_reg, q_reg[DIM_BITS-1]};
    assign r_ge    = (r_shift >= (DIM_BITS+1)'(d_reg));

    // Running product still below the room left: prod + pos < dim
    assign fits = ((W+1)'(prod_reg) + (W+1)'(pos_reg)) < (W+1)'(dim_reg);

    // Option fields from the product history, masked to the field width; unused fields read one
    for (genvar k = 0; k < OPT_FIELDS; k++) begin : g_opt
        if (k < NUM_OPTIONS) begin : g_used
            logic [W-1:0] ext;
            assign ext    = W'(hist_reg[k]);
            assign opt[k] = ext[OPT_W-1:0];
        end
        else begin : g_unused
            assign opt[k] = OPT_W'(1);
        end
    end
    assign valid_wide = VW'(valid_reg);

    // Sequencer
    always_comb
    begin
        state_next        = state_reg;
        out_valid_next    = out_valid_reg;
        dim_next          = dim_reg;
        pos_next          = pos_reg;
        rem_next          = rem_reg;
        d_next            = d_reg;
        sq_next           = sq_reg;
        r_next            = r_reg;
        q_next            = q_reg;
        bit_next          = bit_reg;
        cnt_next          = cnt_reg;
        idx_next          = idx_reg;
        prod_next         = prod_reg;
        valid_next        = valid_reg;
        fac_next          = fac_reg;
        hist_next         = hist_reg;
        opt_largest_next  = opt_largest_reg;
        opt_middle_next   = opt_middle_reg;
        opt_smallest_next = opt_smallest_reg;
        count_next        = count_reg;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (operand.valid)
                begin
                    dim_next   = dim_in;
                    pos_next   = operand.start_position;
                    rem_next   = dim_in;
                    d_next     = DIM_BITS'(2);
                    sq_next    = SQ_W'(4);
                    cnt_next   = '0;
                    valid_next = '0;
                    prod_next  = DIM_BITS'(1);
                    for (int k = 0; k < NUM_OPTIONS; k++)
                    begin
                        hist_next[k] = DIM_BITS'(1);
                    end
                    state_next = (dim_in < DIM_BITS'(2)) ? S_DONE : S_CHECK;
                end
            end
            S_CHECK:
            begin
                // past the square root: what is left is prime
                if (sq_reg > SQ_W'(rem_reg))
                begin
                    d_next = rem_reg;
                end
                r_next     = '0;
                q_next     = rem_reg;
                bit_next   = BIT_W'(DIM_BITS - 1);
                state_next = S_DIV;
            end
            S_DIV:
            begin
                r_next = r_ge ? DIM_BITS'(r_shift - (DIM_BITS+1)'(d_reg))
                              : r_shift[DIM_BITS-1:0];
                q_next = {q_reg[DIM_BITS-2:0], r_ge};
                if (bit_reg == '0)
                begin
                    state_next = S_STEP;
                end
                else
                begin
                    bit_next = bit_reg - 1'b1;
                end
            end
            S_STEP:
            begin
                if (r_reg == '0)
                begin
                    rem_next = q_reg;
                    if (cnt_reg < FCNT_W'(MAX_FACTORS))
                    begin
                        fac_next[cnt_reg[FIDX_W-1:0]] = d_reg;
                        cnt_next = cnt_reg + 1'b1;
                    end
                    if (q_reg == DIM_BITS'(1))
                    begin
                        // at least one factor is stored here: the last factor was just found
                        idx_next   = (cnt_reg < FCNT_W'(MAX_FACTORS))
                                   ? cnt_reg[FIDX_W-1:0]
                                   : FIDX_W'(MAX_FACTORS - 1);
                        state_next = S_MUL;
                    end
                    else
                    begin
                        state_next = S_CHECK;
                    end
                end
                else
                begin
                    d_next     = d_reg + 1'b1;
                    sq_next    = sq_reg + SQ_W'({d_reg, 1'b1});
                    state_next = S_CHECK;
                end
            end
            S_MUL:
            begin
                // product of factors never exceeds the dimension
                prod_next  = DIM_BITS'(prod_reg * fac_reg[idx_reg]);
                state_next = S_CMP;
            end
            S_CMP:
            begin
                if (fits)
                begin
                    valid_next   = valid_reg + 1'b1;
                    hist_next[0] = prod_reg;
                    for (int k = 1; k < NUM_OPTIONS; k++)
                    begin
                        hist_next[k] = hist_reg[k-1];
                    end
                end
                if (idx_reg == '0)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    idx_next   = idx_reg - 1'b1;
                    state_next = S_MUL;
                end
            end
            S_DONE:
            begin
                if (!out_valid_reg || result.ready)
                begin
                    opt_largest_next  = opt[0];
                    opt_middle_next   = opt[1];
                    opt_smallest_next = opt[2];
                    count_next        = valid_wide[CNT_W-1:0];
                    out_valid_next    = 1'b1;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        dim_reg          <= dim_next;
        pos_reg          <= pos_next;
        rem_reg          <= rem_next;
        d_reg            <= d_next;
        sq_reg           <= sq_next;
        r_reg            <= r_next;
        q_reg            <= q_next;
        bit_reg          <= bit_next;
        cnt_reg          <= cnt_next;
        idx_reg          <= idx_next;
        prod_reg         <= prod_next;
        valid_reg        <= valid_next;
        fac_reg          <= fac_next;
        hist_reg         <= hist_next;
        opt_largest_reg  <= opt_largest_next;
        opt_middle_reg   <= opt_middle_next;
        opt_smallest_reg <= opt_smallest_next;
        count_reg        <= count_next;
    end

    // Ports
    assign operand.ready          = (state_reg == S_IDLE);
    assign result.valid           = out_valid_reg;
    assign result.option_largest  = opt_largest_reg;
    assign result.option_middle   = opt_middle_reg;
    assign result.option_smallest = opt_smallest_reg;
    assign result.valid_count     = count_reg;

    // Trial divisor is never below two while dividing
    a_div_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV) |-> (d_reg >= DIM_BITS'(2)))
        else $error("trial divisor below two in divider");

    // Factor count stays within the store
    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> (cnt_reg <= FCNT_W'(MAX_FACTORS)))
        else $error("factor count beyond store size");

    // Fitting products never outnumber stored factors
    a_valid_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (valid_reg <= cnt_reg))
        else $error("valid count exceeds factor count");

    // Running product of factors is never zero
    a_prod_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_CMP) |-> (prod_reg != '0))
        else $error("running product is zero");

    // An accepted item always starts the sequencer
    a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
        (operand.valid && operand.ready) |=> (state_reg != S_IDLE))
        else $error("accepted item did not start work");

endmodule

`default_nettype wire
